@@ rtl/log_domain_arithmetic_unit_defines.svh @@
// Assertion macros for the log-domain arithmetic unit.
// Used by log_domain_arithmetic_unit.sv; expects clk and arst_n in scope.
`ifndef LOG_DOMAIN_ARITHMETIC_UNIT_DEFINES_SVH
`define LOG_DOMAIN_ARITHMETIC_UNIT_DEFINES_SVH

// Require post in the same cycle as pre, outside reset
`define LDAU_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Require post in the cycle after pre, outside reset
`define LDAU_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/ldau_pkg.sv @@
// Package for the log-domain arithmetic unit: opcodes, code constants,
// saturation and the elaboration-time builder for the correction ROM.
// No dependencies.
package ldau_pkg;

	// Operation codes
	typedef enum logic [1:0] {
		OP_LOG_ADD = 2'd0,
		OP_MUL     = 2'd1,
		OP_DIV     = 2'd2,
		OP_MAX3    = 2'd3
	} ldau_op_t;

	// Parameter defaults
	localparam int FRACTION_BITS_DEF      = 16;
	localparam int CORRECTION_ENTRIES_DEF = 256;

	// Correction covers differences 0 .. 16 in natural log units
	localparam int CORR_RANGE      = 16;
	localparam int CORR_RANGE_LOG2 = 4;

	// Fixed-point constants in Q30
	localparam logic [63:0] ONE_Q30        = 64'd1 << 30;
	localparam logic [63:0] LN2_Q30        = 64'd744261118;
	localparam logic [63:0] CORR_RANGE_Q30 = 64'(CORR_RANGE) << 30;

	// Code values
	localparam logic signed [31:0] CODE_ZERO       = 32'sh8000_0000;
	localparam logic signed [31:0] CODE_MAX        = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CODE_MIN_FINITE = 32'sh8000_0001;

	// Clamp a grown sum to the finite code range
	function automatic logic signed [31:0] sat_finite(logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'(CODE_MAX)) begin
			r = CODE_MAX;
		end else if (v < 33'(CODE_MIN_FINITE)) begin
			r = CODE_MIN_FINITE;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Restoring long division, used only while building the ROM
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// ln(1+exp(-x)) for x in Q30, rounded half up to frac_bits fraction bits
	function automatic logic [63:0] corr_entry(logic [63:0] x, int frac_bits);
		logic [63:0] k;
		logic [63:0] r;
		logic [63:0] er;
		logic [63:0] t;
		logic [63:0] q;
		logic [63:0] s;
		logic [63:0] s2;
		logic [63:0] u;
		logic [63:0] sum;
		logic [63:0] ln;
		k  = x / LN2_Q30;
		r  = x - k * LN2_Q30;
		er = ONE_Q30;
		t  = ONE_Q30;
		// e^r by its series
		for (int n = 1; n < 64 && t != 0; n++) begin
			t  = udiv64((t * r) >> 30, 64'(n));
			er = er + t;
		end
		q   = (k < 64'd63) ? (udiv64(64'd1 << 60, er) >> k) : 64'd0;
		s   = udiv64(q << 30, q + (64'd1 << 31));
		s2  = (s * s) >> 30;
		u   = s;
		sum = '0;
		// ln(1+q) as 2*atanh(q/(q+2))
		for (int n = 0; n < 64 && u != 0; n++) begin
			sum = sum + udiv64(u, 64'(2 * n + 1));
			u   = (u * s2) >> 30;
		end
		ln = 2 * sum;
		return (ln + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
	endfunction

	// Value of ROM entry idx, taken at the lower edge of its bin
	function automatic logic [63:0] corr_table_value(logic [63:0] idx, logic [63:0] entries,
		int frac_bits);
		logic [63:0] x;
		x = udiv64(idx * CORR_RANGE_Q30, entries);
		return corr_entry(x, frac_bits);
	endfunction

endpackage

@@ rtl/log_domain_arithmetic_unit.sv @@
// Log-domain arithmetic unit: Q16.16 natural-log codes, log-add via a
// correction ROM, multiply, divide, maximum of three, compare flags.
// Depends on ldau_pkg and log_domain_arithmetic_unit_defines.svh.
//
// Usage: a request enters on in_valid/in_stall with opcode, lhs_log,
// rhs_log and third_log; the result leaves on out_valid/out_stall with
// result_log, lhs_less and operands_equal. A transfer happens at a rising
// edge with valid high and stall low. The code 0x80000000 means zero.
// Five register stages: compare, subtract, multiply by the entry count,
// registered ROM read, final add and select. out_valid comes from the
// stage 5 valid register, which a request reaches through stages 1 to 4 in
// order. Throughput is one request per cycle while out_stall is low; every
// stage is a register stage and the correction ROM is read once per request.
// When the receiver holds out_stall, the output register keeps its result
// and each stage behind it advances only into an empty slot, so bubbles
// collapse before in_stall rises. in_stall rises only with stage one full.
// Reset (arst_n low) clears all valid bits at once; no request is in
// flight afterward and the block takes a request in the next cycle.
`include "log_domain_arithmetic_unit_defines.svh"

module log_domain_arithmetic_unit
	import ldau_pkg::*;
#(
	parameter int FRACTION_BITS      = FRACTION_BITS_DEF,
	parameter int CORRECTION_ENTRIES = CORRECTION_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] lhs_log,
	input  logic signed [31:0] rhs_log,
	input  logic signed [31:0] third_log,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_log,
	output logic               lhs_less,
	output logic               operands_equal
);

	localparam int ENTRY_W   = $clog2(CORRECTION_ENTRIES + 1);
	localparam int PROD_W    = 32 + ENTRY_W;
	localparam int IDX_W     = $clog2(CORRECTION_ENTRIES);
	localparam int IDX_SHIFT = FRACTION_BITS + CORR_RANGE_LOG2;

	typedef logic [FRACTION_BITS-1:0] corr_rom_t [CORRECTION_ENTRIES];

	// Build the correction table at elaboration
	function automatic corr_rom_t build_corr_rom();
		corr_rom_t   rom;
		logic [63:0] val;
		for (int i = 0; i < CORRECTION_ENTRIES; i++) begin
			val    = corr_table_value(64'(i), 64'(CORRECTION_ENTRIES), FRACTION_BITS);
			rom[i] = val[FRACTION_BITS-1:0];
		end
		return rom;
	endfunction

	localparam corr_rom_t CorrRom = build_corr_rom();

	// Valid bits and stage enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// Stage 1 payload
	ldau_op_t           op_s1;
	logic signed [31:0] a_s1, b_s1, c_s1;
	logic               a_zero_s1, b_zero_s1, a_gt_b_s1, b_gt_c_s1, less_s1, equal_s1;

	// Stage 2 payload
	ldau_op_t           op_s2;
	logic signed [31:0] a_s2, hi_s2, max_bc_s2, pass_val_s2;
	logic [31:0]        diff_s2;
	logic signed [32:0] sum_s2;
	logic               any_zero_s2, pass_s2, less_s2, equal_s2;

	// Stage 3 payload
	ldau_op_t           op_s3;
	logic signed [31:0] hi_s3, pass_val_s3, other_s3;
	logic [PROD_W-1:0]  prod_s3;
	logic               pass_s3, less_s3, equal_s3;

	// Stage 4 payload
	ldau_op_t                 op_s4;
	logic signed [31:0]       hi_s4, pass_val_s4, other_s4;
	logic [FRACTION_BITS-1:0] corr_s4;
	logic                     pass_s4, less_s4, equal_s4;

	// Stage 5 payload (output register)
	logic signed [31:0] result_s5;
	logic               less_s5, equal_s5;

	// Combinational helpers
	logic [PROD_W-1:0]  idx_full;
	logic               idx_in_range;
	logic signed [32:0] corr_ext;
	logic signed [32:0] add_sum;
	logic signed [31:0] log_add_res;

	// Advance a stage when it is empty or its successor moves
	assign en_s5    = !valid_s5 || !out_stall;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// Track valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: register operands and compare
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			op_s1     <= ldau_op_t'(opcode);
			a_s1      <= lhs_log;
			b_s1      <= rhs_log;
			c_s1      <= third_log;
			a_zero_s1 <= (lhs_log == CODE_ZERO);
			b_zero_s1 <= (rhs_log == CODE_ZERO);
			a_gt_b_s1 <= (lhs_log > rhs_log);
			b_gt_c_s1 <= (rhs_log > third_log);
			less_s1   <= (lhs_log < rhs_log);
			equal_s1  <= (lhs_log == rhs_log);
		end
	end

	// Stage 2: order operands, take the difference, the sum (a - b for divide) and max(b, c)
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			op_s2       <= op_s1;
			a_s2        <= a_s1;
			hi_s2       <= a_gt_b_s1 ? a_s1 : b_s1;
			diff_s2     <= a_gt_b_s1 ? 32'(a_s1 - b_s1) : 32'(b_s1 - a_s1);
			sum_s2      <= (op_s1 == OP_DIV) ? (33'(a_s1) - 33'(b_s1))
			                                 : (33'(a_s1) + 33'(b_s1));
			max_bc_s2   <= b_gt_c_s1 ? b_s1 : c_s1;
			any_zero_s2 <= a_zero_s1 || b_zero_s1;
			pass_s2     <= a_zero_s1 || b_zero_s1;
			pass_val_s2 <= a_zero_s1 ? b_s1 : a_s1;
			less_s2     <= less_s1;
			equal_s2    <= equal_s1;
		end
	end

	// Stage 3: scale the difference to a bin, finish multiply/divide/max
	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			op_s3       <= op_s2;
			hi_s3       <= hi_s2;
			prod_s3     <= PROD_W'(diff_s2) * PROD_W'(CORRECTION_ENTRIES);
			pass_s3     <= pass_s2;
			pass_val_s3 <= pass_val_s2;
			less_s3     <= less_s2;
			equal_s3    <= equal_s2;
			if (op_s2 == OP_MAX3) begin
				other_s3 <= (a_s2 > max_bc_s2) ? a_s2 : max_bc_s2;
			end else if (any_zero_s2) begin
				other_s3 <= CODE_ZERO;
			end else begin
				other_s3 <= sat_finite(sum_s2);
			end
		end
	end

	// Stage 4: look up the correction, zero past the table range
	assign idx_full     = prod_s3 >> IDX_SHIFT;
	assign idx_in_range = idx_full < PROD_W'(CORRECTION_ENTRIES);

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			op_s4       <= op_s3;
			hi_s4       <= hi_s3;
			corr_s4     <= idx_in_range ? CorrRom[idx_full[IDX_W-1:0]] : '0;
			pass_s4     <= pass_s3;
			pass_val_s4 <= pass_val_s3;
			other_s4    <= other_s3;
			less_s4     <= less_s3;
			equal_s4    <= equal_s3;
		end
	end

	// Stage 5: add the correction and select the result
	assign corr_ext    = {{(33 - FRACTION_BITS){1'b0}}, corr_s4};
	assign add_sum     = 33'(hi_s4) + corr_ext;
	assign log_add_res = pass_s4 ? pass_val_s4 : sat_finite(add_sum);

	always_ff @(posedge clk) begin
		if (en_s5 && valid_s4) begin
			less_s5  <= less_s4;
			equal_s5 <= equal_s4;
			case (op_s4)
				OP_LOG_ADD: result_s5 <= log_add_res;
				default:    result_s5 <= other_s4;
			endcase
		end
	end

	assign out_valid      = valid_s5;
	assign result_log     = result_s5;
	assign lhs_less       = less_s5;
	assign operands_equal = equal_s5;

	// Checks on pipeline control and flag consistency
	`LDAU_ASSERT_NOW(stall_needs_full_s1, in_stall, valid_s1, "in_stall with stage 1 empty")
	`LDAU_ASSERT_NEXT(drain_into_output, valid_s4 && !valid_s5, out_valid, "stage 4 did not drain")
	`LDAU_ASSERT_NOW(equal_not_less, out_valid && operands_equal, !lhs_less, "equal and less both set")

endmodule

@@ dv/log_domain_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for log_domain_arithmetic_unit: directed and random requests with a
// scoreboard that predicts every result from the operands. Depends on ldau_pkg.
module log_domain_arithmetic_unit_tb;
	import ldau_pkg::*;

	localparam int FRAC          = 16;
	localparam int ROM_ENTRIES   = 256;
	localparam int RANDOM_ITEMS  = 650;
	localparam int QUIET_TAIL    = 100;
	localparam int DRAIN_CYCLES  = 12;
	localparam int STALL_LIMIT   = 2000;

	// One predicted result
	typedef struct packed {
		logic signed [31:0] code;
		logic               lhs_less;
		logic               operands_equal;
	} ldau_outcome_t;

	// Predict results of accepted requests and compare them with the block
	class ldau_scoreboard;
		ldau_outcome_t awaited[$];
		longint        softplus_rom[ROM_ENTRIES];
		int            mismatches;

		function new();
			longint unsigned x;
			mismatches = 0;
			// Fill each bin with ln(1+exp(-x)) at its lower edge
			for (int i = 0; i < ROM_ENTRIES; i++) begin
				x = (longint'(i) * (longint'(CORR_RANGE) << 30)) / ROM_ENTRIES;
				softplus_rom[i] = longint'(softplus_at(x));
			end
		endfunction

		// ln(1+exp(-x)), x in Q30, rounded half up to FRAC fraction bits
		function longint unsigned softplus_at(longint unsigned x);
			longint unsigned k, r, er, t, q, s, s2, u, acc, ln;
			k  = x / LN2_Q30;
			r  = x - k * LN2_Q30;
			er = ONE_Q30;
			t  = ONE_Q30;
			// exp(r) by its series
			for (int n = 1; n < 64 && t != 0; n++) begin
				t  = ((t * r) >> 30) / longint'(n);
				er = er + t;
			end
			q   = (k < 63) ? (((64'd1 << 60) / er) >> k) : 64'd0;
			s   = (q << 30) / (q + (64'd1 << 31));
			s2  = (s * s) >> 30;
			u   = s;
			acc = 0;
			// ln(1+q) as twice the atanh series of q/(q+2)
			for (int n = 0; n < 64 && u != 0; n++) begin
				acc = acc + u / longint'(2 * n + 1);
				u   = (u * s2) >> 30;
			end
			ln = 2 * acc;
			return (ln + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		endfunction

		// Correction for a non-negative code difference
		function longint bin_correction(longint unsigned d);
			longint unsigned idx;
			idx = (d * ROM_ENTRIES) / (longint'(CORR_RANGE) << FRAC);
			if (idx >= ROM_ENTRIES) begin
				return 0;
			end
			return softplus_rom[idx];
		endfunction

		// Clamp to the finite code range so a finite result never becomes zero
		function longint clamp_code(longint v);
			if (v > CODE_MAX) begin
				return CODE_MAX;
			end
			if (v < CODE_MIN_FINITE) begin
				return CODE_MIN_FINITE;
			end
			return v;
		endfunction

		// Note an accepted request and queue its predicted result
		function void note_request(ldau_op_t op, logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c);
			longint        la, lb, lc, hi, lo, res;
			ldau_outcome_t want;
			la = a;
			lb = b;
			lc = c;
			case (op)
				OP_LOG_ADD: begin
					// Pass the other operand through when one is zero
					if (a == CODE_ZERO) begin
						res = lb;
					end else if (b == CODE_ZERO) begin
						res = la;
					end else begin
						hi  = (la > lb) ? la : lb;
						lo  = (la > lb) ? lb : la;
						res = clamp_code(hi + bin_correction(hi - lo));
					end
				end
				OP_MUL: begin
					res = (a == CODE_ZERO || b == CODE_ZERO) ? longint'(CODE_ZERO)
						: clamp_code(la + lb);
				end
				OP_DIV: begin
					res = (a == CODE_ZERO || b == CODE_ZERO) ? longint'(CODE_ZERO)
						: clamp_code(la - lb);
				end
				default: begin
					res = (lb > lc) ? lb : lc;
					if (la > res) begin
						res = la;
					end
				end
			endcase
			want.code           = res[31:0];
			want.lhs_less       = (la < lb);
			want.operands_equal = (a == b);
			awaited.push_back(want);
		endfunction

		task report_mismatch(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one accepted result with the oldest prediction
		task check_result(logic signed [31:0] code, logic less, logic eq);
			ldau_outcome_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result %h with no request pending", code));
			end else begin
				want = awaited.pop_front();
				if (code !== want.code) begin
					report_mismatch($sformatf("result_log %h, predicted %h", code, want.code));
				end
				if (less !== want.lhs_less) begin
					report_mismatch($sformatf("lhs_less %b, predicted %b", less,
						want.lhs_less));
				end
				if (eq !== want.operands_equal) begin
					report_mismatch($sformatf("operands_equal %b, predicted %b", eq,
						want.operands_equal));
				end
			end
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode    = '0;
	logic signed [31:0] lhs_log   = '0;
	logic signed [31:0] rhs_log   = '0;
	logic signed [31:0] third_log = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_log;
	logic               lhs_less;
	logic               operands_equal;

	ldau_scoreboard board;
	bit             gaps_on   = 1'b1;
	int             stall_left = 0;
	int             quiet_cycles = 0;

	log_domain_arithmetic_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.lhs_log        (lhs_log),
		.rhs_log        (rhs_log),
		.third_log      (third_log),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_log     (result_log),
		.lhs_less       (lhs_less),
		.operands_equal (operands_equal)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Present one request, optionally after an idle burst, and hold it until taken
	task send_request(ldau_op_t op, logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		lhs_log   <= a;
		rhs_log   <= b;
		third_log <= c;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		board.note_request(op, a, b, c);
	endtask

	// Pick an operand: special codes, full random, or close to another operand
	function automatic logic signed [31:0] pick_code(logic signed [31:0] near);
		logic signed [31:0] v;
		case ($urandom_range(0, 11))
			0:       v = CODE_ZERO;
			1:       v = CODE_MAX;
			2:       v = CODE_MIN_FINITE;
			3, 4, 5: v = $urandom;
			6, 7, 8: v = near + $signed($urandom_range(0, 40 << 16)) - (20 << 16);
			9, 10:   v = near + $signed($urandom_range(0, 8192)) - 4096;
			default: v = near;
		endcase
		return v;
	endfunction

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			board.check_result(result_log, lhs_less, operands_equal);
		end
	end

	// Drop the run if neither side moves for too long
	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL log_domain_arithmetic_unit");
			$finish;
		end
	end

	initial begin
		ldau_op_t           op;
		logic signed [31:0] a, b, c;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Log-add: zero operands, equal operands, saturation, bin edges, huge gap
		send_request(OP_LOG_ADD, CODE_ZERO, CODE_ZERO, $urandom);
		send_request(OP_LOG_ADD, CODE_ZERO, 32'sh0001_0000, $urandom);
		send_request(OP_LOG_ADD, 32'shFFFE_0000, CODE_ZERO, $urandom);
		send_request(OP_LOG_ADD, 32'sh0001_0000, 32'sh0001_0000, $urandom);
		send_request(OP_LOG_ADD, CODE_MAX, CODE_MAX, $urandom);
		send_request(OP_LOG_ADD, CODE_MIN_FINITE, CODE_MIN_FINITE, $urandom);
		send_request(OP_LOG_ADD, 32'sh0000_0000, 32'sh000F_FFFF, $urandom);
		send_request(OP_LOG_ADD, 32'sh0010_0000, 32'sh0000_0000, $urandom);
		send_request(OP_LOG_ADD, 32'sh0000_1000, 32'sh0000_0000, $urandom);
		send_request(OP_LOG_ADD, CODE_MAX, CODE_MIN_FINITE, $urandom);
		// Multiply and divide: zero operands and overflow both ways
		send_request(OP_MUL, CODE_ZERO, 32'sh0000_0005, $urandom);
		send_request(OP_MUL, 32'sh0000_0005, CODE_ZERO, $urandom);
		send_request(OP_MUL, CODE_MAX, CODE_MAX, $urandom);
		send_request(OP_MUL, CODE_MIN_FINITE, CODE_MIN_FINITE, $urandom);
		send_request(OP_MUL, 32'sh0002_0000, 32'shFFFF_0000, $urandom);
		send_request(OP_DIV, 32'sh0001_0000, CODE_ZERO, $urandom);
		send_request(OP_DIV, CODE_ZERO, CODE_ZERO, $urandom);
		send_request(OP_DIV, CODE_MAX, CODE_MIN_FINITE, $urandom);
		send_request(OP_DIV, CODE_MIN_FINITE, CODE_MAX, $urandom);
		// Maximum of three: zero code loses, each position wins once
		send_request(OP_MAX3, CODE_ZERO, CODE_ZERO, CODE_ZERO);
		send_request(OP_MAX3, CODE_ZERO, 32'sh0000_0003, -32'sd5);
		send_request(OP_MAX3, -32'sd1, CODE_ZERO, -32'sd7);
		send_request(OP_MAX3, CODE_MIN_FINITE, CODE_ZERO, CODE_MAX);
		send_request(OP_MAX3, 32'sh0000_0007, 32'sh0000_0007, 32'sh0000_0007);

		// Random requests; idling on or off per segment, none in the tail
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 60 == 0) begin
				gaps_on = ($urandom_range(0, 2) != 0);
			end
			if (i >= RANDOM_ITEMS - QUIET_TAIL) begin
				gaps_on = 1'b0;
			end
			op = ldau_op_t'(2'($urandom_range(0, 3)));
			a  = pick_code($urandom);
			b  = pick_code(a);
			c  = pick_code(($urandom_range(0, 1) != 0) ? a : b);
			send_request(op, a, b, c);
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (board.awaited.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("PASS log_domain_arithmetic_unit");
		end else begin
			$display("FAIL log_domain_arithmetic_unit");
		end
		$finish;
	end

endmodule
